// ----- design/tcte_pkg.sv -----
package tcte_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int POS_W    = 11;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int TAB_STEP = 8;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic copy;
    logic fill;
    logic load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scroll;
    logic clear;
    logic copy_last;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

// ----- design/tcte_item_if.sv -----
interface tcte_item_if;
  import tcte_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0] character;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;

  modport source (output valid, action, character, column, row, input ready);
  modport sink   (input valid, action, character, column, row, output ready);
endinterface

// ----- design/tcte_result_if.sv -----
interface tcte_result_if;
  import tcte_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;

  modport source (output valid, cursor_column, cursor_row, cursor_position, cell_value,
                  scrolled, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_position, cell_value,
                  scrolled, output ready);
endinterface

// ----- design/tcte_cfg_if.sv -----
interface tcte_cfg_if;
  import tcte_pkg::*;

  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

// ----- design/tcte_ram.sv -----
module tcte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/tcte_ctrl.sv -----
module tcte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcte_pkg::sts_t sts,
  output tcte_pkg::cmd_t cmd
);
  import tcte_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_COPY = 5'b00100,
    S_FILL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   busy;
  logic   take;

  // a new item may enter while the previous result is loaded
  assign in_ready = (state == S_IDLE) || (state == S_DONE && sts.out_free);
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd.accept = take;
    cmd.exec   = (state == S_EXEC);
    cmd.copy   = (state == S_COPY);
    cmd.fill   = (state == S_FILL);
    cmd.load   = (state == S_DONE) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.clear)       state_next = S_FILL;
        else if (sts.scroll) state_next = S_COPY;
        else                 state_next = S_DONE;
      end
      S_COPY: begin
        if (sts.copy_last) state_next = S_FILL;
      end
      S_FILL: begin
        if (sts.fill_last) state_next = busy ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = take ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // reset starts in the fill sweep to blank the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      if (take)          busy <= 1'b1;
      else if (cmd.load) busy <= 1'b0;
    end
  end

endmodule

// ----- design/tcte_dp.sv -----
module tcte_dp #(
  parameter int COLUMNS = tcte_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcte_pkg::ROWS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tcte_pkg::cmd_t                cmd,
  output tcte_pkg::sts_t                sts,
  input  logic [tcte_pkg::ACTION_W-1:0] action,
  input  logic [tcte_pkg::CHAR_W-1:0]   character,
  input  logic [tcte_pkg::COL_W-1:0]    column,
  input  logic [tcte_pkg::ROW_W-1:0]    row,
  input  logic                          attr_we,
  input  logic [tcte_pkg::ATTR_W-1:0]   attr_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcte_pkg::COL_W-1:0]    cursor_column,
  output logic [tcte_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcte_pkg::POS_W-1:0]    cursor_position,
  output logic [tcte_pkg::CELL_W-1:0]   cell_value,
  output logic                          scrolled
);
  import tcte_pkg::*;

  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int COPY_CELLS = COLUMNS * (ROWS - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(COLUMNS) + AW'(c);
  endfunction

  // latched item
  action_t           act_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;

  logic [ATTR_W-1:0] attr;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [AW-1:0]     sweep;
  logic [CELL_W-1:0] blank;
  logic              copy_wr;
  logic [AW-1:0]     copy_addr;
  logic              scrolled_q;
  logic              hit_q;

  // put decode
  logic [CW-1:0]     put_col;
  logic [RW:0]       put_row;
  logic              put_we;
  logic [CW-1:0]     put_wcol;
  logic [RW-1:0]     put_wrow;
  logic [CHAR_W-1:0] put_ch;
  logic [CW:0]       tab_sum;
  logic              put_scroll;

  logic              in_range;
  logic [RW-1:0]     ex_row;
  logic [CW-1:0]     ex_col;
  logic [AW-1:0]     ex_addr;
  logic              ex_we;
  logic [CELL_W-1:0] ex_data;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic              fill_step;

  always_comb begin
    put_col  = cur_col;
    put_row  = {1'b0, cur_row};
    put_we   = 1'b0;
    put_wcol = cur_col;
    put_wrow = cur_row;
    put_ch   = char_q;
    tab_sum  = ({1'b0, cur_col} + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
    case (char_q)
      CH_NL: begin
        put_col = '0;
        put_row = put_row + 1'b1;
      end
      CH_CR: begin
        put_col = '0;
      end
      CH_TAB: begin
        if (tab_sum >= (CW+1)'(COLUMNS)) begin
          put_col = '0;
          put_row = put_row + 1'b1;
        end else begin
          put_col = tab_sum[CW-1:0];
        end
      end
      CH_BS: begin
        // erase-back; col 0 wraps to row above's last col; no-op at origin
        if (cur_col != '0) begin
          put_col  = cur_col - 1'b1;
          put_we   = 1'b1;
          put_wcol = cur_col - 1'b1;
          put_ch   = CH_SPACE;
        end else if (cur_row != '0) begin
          put_col  = CW'(COLUMNS - 1);
          put_row  = put_row - 1'b1;
          put_we   = 1'b1;
          put_wcol = CW'(COLUMNS - 1);
          put_wrow = cur_row - 1'b1;
          put_ch   = CH_SPACE;
        end
      end
      default: begin
        put_we = 1'b1;
        if (cur_col == CW'(COLUMNS - 1)) begin
          put_col = '0;
          put_row = put_row + 1'b1;
        end else begin
          put_col = cur_col + 1'b1;
        end
      end
    endcase
    put_scroll = (put_row == (RW+1)'(ROWS));
  end

  assign in_range = (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS);
  assign ex_row   = (act_q == ACT_PUT) ? put_wrow : RW'(row_q);
  assign ex_col   = (act_q == ACT_PUT) ? put_wcol : CW'(col_q);
  assign ex_addr  = cell_addr(ex_row, ex_col);
  assign ex_we    = (act_q == ACT_PUT) ? put_we : ((act_q == ACT_WRITE) && in_range);
  assign ex_data  = {attr, (act_q == ACT_PUT) ? put_ch : char_q};

  // copy writes land in the cycle after their reads and own the write port
  assign fill_step = cmd.fill && !copy_wr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ex_addr;
    ram_wdata = ex_data;
    if (copy_wr) begin
      ram_we    = 1'b1;
      ram_waddr = copy_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.fill) begin
      ram_we    = 1'b1;
      ram_waddr = sweep;
      ram_wdata = blank;
    end else if (cmd.exec) begin
      ram_we    = ex_we;
    end
  end

  assign ram_re    = cmd.copy || (cmd.exec && act_q == ACT_READ && in_range);
  assign ram_raddr = cmd.copy ? AW'(sweep + AW'(COLUMNS)) : ex_addr;

  tcte_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.scroll    = (act_q == ACT_PUT) && put_scroll;
    sts.clear     = (act_q == ACT_CLEAR);
    sts.copy_last = (sweep == AW'(COPY_CELLS - 1));
    sts.fill_last = !copy_wr && (sweep == AW'(CELLS - 1));
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q  <= action_t'(action);
      char_q <= character;
      col_q  <= column;
      row_q  <= row;
    end
    if (cmd.exec) begin
      scrolled_q <= (act_q == ACT_PUT) && put_scroll;
      hit_q      <= (act_q == ACT_READ) && in_range;
    end
    if (cmd.copy) begin
      copy_addr <= sweep;
    end
    if (cmd.load) begin
      cursor_column   <= COL_W'(cur_col);
      cursor_row      <= ROW_W'(cur_row);
      cursor_position <= POS_W'(cell_addr(cur_row, cur_col));
      cell_value      <= hit_q ? ram_rdata : '0;
      scrolled        <= scrolled_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= RESET_ATTR;
      cur_col   <= '0;
      cur_row   <= '0;
      sweep     <= '0;
      blank     <= {RESET_ATTR, CH_SPACE};
      copy_wr   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (attr_we) attr <= attr_data;
      copy_wr <= cmd.copy;
      if (cmd.exec) begin
        sweep <= '0;
        blank <= {attr, CH_SPACE};
        if (act_q == ACT_PUT) begin
          cur_col <= put_col;
          cur_row <= put_scroll ? RW'(ROWS - 1) : put_row[RW-1:0];
        end else if (act_q == ACT_CLEAR) begin
          cur_col <= '0;
          cur_row <= '0;
        end
      end else if (cmd.copy) begin
        sweep <= sts.copy_last ? AW'(COPY_CELLS) : sweep + 1'b1;
      end else if (fill_step) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.load)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- design/text_console_teletype_engine_core.sv -----
// Each accepted item passes the execute step, then the result-load step, which waits
// while the previous result is still held. Put without scroll, cell write and cell
// read: the next item is taken during the result-load step of the previous one.
// Scroll: rows move up with one RAM copy per cycle, then the bottom row is filled.
// Clear: the whole store is blanked. Reset (rst, synchronous): cursor to origin,
// attribute 7, then a blanking pass over all COLUMNS*ROWS cells, taking no item.
module text_console_teletype_engine_core #(
  parameter int COLUMNS = tcte_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcte_pkg::ROWS_DEFAULT
) (
  input logic            clk,
  input logic            rst,
  tcte_item_if.sink      items,
  tcte_result_if.source  results,
  tcte_cfg_if.sink       cfg
);
  import tcte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  tcte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcte_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (items.action),
    .character       (items.character),
    .column          (items.column),
    .row             (items.row),
    .attr_we         (cfg.valid),
    .attr_data       (cfg.text_attribute),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .cursor_column   (results.cursor_column),
    .cursor_row      (results.cursor_row),
    .cursor_position (results.cursor_position),
    .cell_value      (results.cell_value),
    .scrolled        (results.scrolled)
  );

  a_no_take_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill || cmd.copy) |-> !items.ready)
    else $error("item taken during a store sweep");

  a_exec_follows_take: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> cmd.exec)
    else $error("accepted item not executed");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!results.valid || results.ready))
    else $error("pending result overwritten");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (int'(results.cursor_column) < COLUMNS
                       && int'(results.cursor_row) < ROWS))
    else $error("cursor out of range");

endmodule
